// File: rtl/frrs_pkg.sv
`timescale 1ns / 1ps
package frrs_pkg;
   localparam int MaxTargets = 16;
   localparam int MaxSessions = 64;
   localparam int TgtW = $clog2(MaxTargets);
   localparam int SesW = $clog2(MaxSessions);

   localparam logic [2:0] RegNumTargets = 3'd0;
   localparam logic [2:0] RegOnlyFirst = 3'd1;
   localparam logic [2:0] RegSessionMode = 3'd2;
   localparam logic [2:0] RegRetryTime = 3'd3;
   localparam logic [2:0] RegSessTimeout = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_ALLOC, ST_RR, ST_DONE
   } state_type;

   // word passed along the session cell row
   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [3:0]  dest;
      logic [31:0] stamp;
   } sess_type;
endpackage

// File: rtl/failover_round_robin_selector_core.sv
`timescale 1ns / 1ps
// Failover round robin selector.
// Request channel (req_*): one word per connection event. opcode 0 asks
// for a destination for client_addr at time now; opcode 1 reports that
// fail_target failed at time now. Response channel (rsp_*): one word per
// request carrying the chosen destination and status flags.
// Sessions live in a ring of MaxSessions cells; every cycle of a scan the
// ring rotates one cell, so the head cell is inspected, aged out, matched
// or refreshed, then handed back to the tail. A select in session mode
// takes one full rotation for the lookup; without a live match it then
// runs the round robin search, one destination per cycle (up to
// MaxTargets), and a second rotation claims the lowest free entry and
// writes the picked destination into it. A session hit is answered after
// the lookup, a select outside session mode runs only the round robin
// search, and a failure report is answered without any scan.
// One request is in flight at a time; req_ready is low until the response
// is taken, so a stalled receiver simply holds the block.
// Reset (synchronous) empties the session table, marks every destination
// good and restores the register defaults. Registers sit on an APB port.
module failover_round_robin_selector_core
   import frrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_client_addr,
   input  logic [31:0] req_now,
   input  logic [3:0]  req_fail_target,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_target,
   output logic        rsp_from_session,
   output logic        rsp_revived,
   output logic        rsp_fallback,
   output logic        rsp_table_full,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   // configuration
   logic [4:0]  num_targets_ff;
   logic        only_first_ff, session_mode_ff;
   logic [31:0] retry_time_ff, sess_timeout_ff;
   logic        wr;
   logic [2:0]  ridx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_targets_ff <= 5'd1;
         only_first_ff <= 1'b0;
         session_mode_ff <= 1'b0;
         retry_time_ff <= '0;
         sess_timeout_ff <= 32'd3600;
      end else if (wr) begin
         unique case (ridx)
            RegNumTargets:  num_targets_ff <= csr_pwdata[4:0];
            RegOnlyFirst:   only_first_ff <= csr_pwdata[0];
            RegSessionMode: session_mode_ff <= csr_pwdata[0];
            RegRetryTime:   retry_time_ff <= csr_pwdata;
            RegSessTimeout: sess_timeout_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         RegNumTargets:  csr_prdata = {27'd0, num_targets_ff};
         RegOnlyFirst:   csr_prdata = {31'd0, only_first_ff};
         RegSessionMode: csr_prdata = {31'd0, session_mode_ff};
         RegRetryTime:   csr_prdata = retry_time_ff;
         RegSessTimeout: csr_prdata = sess_timeout_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // session ring
   sess_type ring [MaxSessions];
   sess_type head, tail_in;
   logic     shift;

   for (genvar g = 0; g < MaxSessions; g++) begin : g_ring
      sess_type d;
      if (g == MaxSessions - 1) begin : g_tail
         assign d = tail_in;
      end else begin : g_mid
         assign d = ring[g+1];
      end
      frrs_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .d_in(d),
         .q(ring[g]));
   end
   assign head = ring[0];

   // request state
   state_type   state_ff, state_in;
   logic [31:0] addr_ff, now_ff;
   logic [SesW:0] cnt_ff, cnt_in;
   logic        match_ff, match_in;    // live session found; at scan end, also kept
   logic        slot_ff, slot_in;      // free entry taken
   logic [3:0]  tgt_ff, tgt_in;
   logic        fs_ff, fs_in, rv_ff, rv_in, fb_ff, fb_in, tf_ff, tf_in;
   logic [TgtW:0] tries_ff, tries_in;

   logic [MaxTargets-1:0] bad_ff, bad_in;
   logic [31:0] ftime_ff [MaxTargets];
   logic [TgtW-1:0] rr_last_ff, rr_last_in;
   logic rr_started_ff, rr_started_in;

   logic [4:0] n_eff;
   logic [TgtW-1:0] cand;
   logic [32:0] deadline;
   logic expired, retry_ok;

   always_comb begin
      if (num_targets_ff == 5'd0) n_eff = 5'd1;
      else if (num_targets_ff > 5'(MaxTargets)) n_eff = 5'(MaxTargets);
      else n_eff = num_targets_ff;
   end

   always_comb begin
      cand = '0;
      if (rr_started_ff && !(only_first_ff && tries_ff == '0)) begin
         if (5'(rr_last_ff) + 5'd1 < n_eff) cand = rr_last_ff + 1'b1;
      end
   end
   assign deadline = {1'b0, ftime_ff[cand]} + {1'b0, retry_time_ff};
   assign retry_ok = (retry_time_ff != '0) && ({1'b0, now_ff} > deadline);
   assign expired = (now_ff - head.stamp) > sess_timeout_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_target = tgt_ff;
   assign rsp_from_session = fs_ff;
   assign rsp_revived = rv_ff;
   assign rsp_fallback = fb_ff;
   assign rsp_table_full = tf_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode) state_in = ST_DONE;
               else if (session_mode_ff) state_in = ST_SCAN;
               else state_in = ST_RR;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == (SesW+1)'(MaxSessions - 1))
               state_in = match_in ? ST_DONE : ST_RR;
         end
         ST_ALLOC: begin
            if (cnt_ff == (SesW+1)'(MaxSessions - 1)) state_in = ST_DONE;
         end
         ST_RR: begin
            if (!bad_ff[cand] || retry_ok || tries_ff + 1'b1 >= (TgtW+1)'(n_eff))
               state_in = session_mode_ff ? ST_ALLOC : ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      shift = 1'b0;
      tail_in = head;
      cnt_in = cnt_ff;
      match_in = match_ff;
      slot_in = slot_ff;
      tgt_in = tgt_ff;
      fs_in = fs_ff; rv_in = rv_ff; fb_in = fb_ff; tf_in = tf_ff;
      tries_in = tries_ff;
      bad_in = bad_ff;
      rr_last_in = rr_last_ff;
      rr_started_in = rr_started_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0; match_in = 1'b0; slot_in = 1'b0; tries_in = '0;
            fs_in = 1'b0; rv_in = 1'b0; fb_in = 1'b0; tf_in = 1'b0;
            tgt_in = req_fail_target;
            if (req_valid && req_opcode)
               bad_in[req_fail_target[TgtW-1:0]] = 1'b1;
         end
         ST_SCAN: begin
            shift = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (head.valid) begin
               if (expired) begin
                  tail_in.valid = 1'b0;
               end else if (!match_ff && head.addr == addr_ff) begin
                  match_in = 1'b1;
                  if (5'(head.dest) < n_eff && !bad_ff[head.dest[TgtW-1:0]]) begin
                     tgt_in = head.dest; fs_in = 1'b1;
                     tail_in.stamp = now_ff;
                  end else begin
                     tail_in.valid = 1'b0;
                  end
               end
            end
            if (cnt_ff == (SesW+1)'(MaxSessions - 1)) begin
               match_in = match_in && fs_in;
               cnt_in = '0;
            end
         end
         ST_ALLOC: begin
            // destination is already picked; claim the lowest free cell
            shift = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (!head.valid && !slot_ff) begin
               slot_in = 1'b1;
               tail_in.valid = 1'b1;
               tail_in.addr = addr_ff;
               tail_in.dest = tgt_ff;
               tail_in.stamp = now_ff;
            end
            if (cnt_ff == (SesW+1)'(MaxSessions - 1)) begin
               tf_in = !slot_in;
               cnt_in = '0;
            end
         end
         ST_RR: begin
            tries_in = tries_ff + 1'b1;
            rr_last_in = cand;
            rr_started_in = 1'b1;
            if (!bad_ff[cand]) begin
               tgt_in = 4'(cand);
            end else if (retry_ok) begin
               bad_in[cand] = 1'b0; tgt_in = 4'(cand); rv_in = 1'b1;
            end else if (tries_ff + 1'b1 >= (TgtW+1)'(n_eff)) begin
               bad_in = '0; tgt_in = '0; rr_last_in = '0; fb_in = 1'b1;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bad_ff <= '0;
         rr_last_ff <= '0;
         rr_started_ff <= 1'b0;
         slot_ff <= 1'b0;
         for (int k = 0; k < MaxTargets; k++) ftime_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         bad_ff <= bad_in;
         rr_last_ff <= rr_last_in;
         rr_started_ff <= rr_started_in;
         slot_ff <= slot_in;
         if (state_ff == ST_IDLE && req_valid && req_opcode)
            ftime_ff[req_fail_target[TgtW-1:0]] <= req_now;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         addr_ff <= req_client_addr;
         now_ff <= req_now;
      end
      cnt_ff <= cnt_in;
      match_ff <= match_in;
      tgt_ff <= tgt_in;
      fs_ff <= fs_in; rv_ff <= rv_in; fb_ff <= fb_in; tf_ff <= tf_in;
      tries_ff <= tries_in;
   end
endmodule

// File: rtl/frrs_cell.sv
`timescale 1ns / 1ps
module frrs_cell
   import frrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  sess_type d_in,
   output sess_type q
);
   sess_type q_ff, q_in;
   logic     vld_ff, vld_in;

   always_comb begin
      q_in = shift ? d_in : q_ff;
      vld_in = shift ? d_in.valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      q = q_ff;
      q.valid = vld_ff;
   end
endmodule

// File: verif/failover_round_robin_selector_core_tb.sv
`timescale 1ns / 1ps
module failover_round_robin_selector_core_tb;
   import frrs_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 200;
   localparam logic OpSelect = 1'b0;
   localparam logic OpFail = 1'b1;

   typedef struct {
      logic        opcode;
      logic [31:0] client_addr;
      logic [31:0] now;
      logic [3:0]  fail_target;
   } conn_word_type;

   typedef struct {
      logic [3:0] target;
      logic       from_session;
      logic       revived;
      logic       fallback;
      logic       table_full;
   } pick_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [31:0] req_client_addr = '0;
   logic [31:0] req_now = '0;
   logic [3:0]  req_fail_target = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_target;
   logic        rsp_from_session;
   logic        rsp_revived;
   logic        rsp_fallback;
   logic        rsp_table_full;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #1 clock = ~clock;

   failover_round_robin_selector_core u_dut (.*);

   // ---------------------------------------------------------------------
   // Predictor state: destination health, rotation point, session table
   // and a shadow of the registers.
   // ---------------------------------------------------------------------
   logic [4:0]  cfg_num_targets = 5'd1;
   logic        cfg_only_first = 1'b0;
   logic        cfg_session_mode = 1'b0;
   logic [31:0] cfg_retry_time = '0;
   logic [31:0] cfg_sess_timeout = 32'd3600;

   logic        dest_bad [MaxTargets];
   logic [31:0] dest_fail_time [MaxTargets];
   logic [3:0]  rr_last = '0;
   logic        rr_started = 1'b0;
   logic        sess_valid [MaxSessions];
   logic [31:0] sess_addr [MaxSessions];
   logic [3:0]  sess_dest [MaxSessions];
   logic [31:0] sess_time [MaxSessions];

   conn_word_type  pending_words[$];
   pick_word_type  expected_picks[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;       // no idling on either side while set
   logic [31:0] clock_now = 32'd100;

   initial begin
      for (int i = 0; i < MaxTargets; i++) begin
         dest_bad[i] = 1'b0;
         dest_fail_time[i] = '0;
      end
      for (int i = 0; i < MaxSessions; i++) sess_valid[i] = 1'b0;
   end

   // Compute the response for one accepted word and update predictor state.
   function automatic pick_word_type predict_pick(conn_word_type w);
      pick_word_type p;
      int n;
      int slot;
      int match;
      int c;
      logic have;
      logic [31:0] age;
      p = '{default: '0};
      have = 1'b0;
      slot = -1;
      if (w.opcode == OpFail) begin
         // 4-bit index is always below MaxTargets here
         dest_bad[w.fail_target] = 1'b1;
         dest_fail_time[w.fail_target] = w.now;
         p.target = w.fail_target;
         return p;
      end
      n = cfg_num_targets;
      if (n < 1) n = 1;
      if (n > MaxTargets) n = MaxTargets;
      if (cfg_session_mode) begin
         match = -1;
         // age out every expired entry, remember first live match
         for (int i = 0; i < MaxSessions; i++) begin
            if (sess_valid[i]) begin
               age = w.now - sess_time[i];
               if (age > cfg_sess_timeout) sess_valid[i] = 1'b0;
               else if (match < 0 && sess_addr[i] == w.client_addr) match = i;
            end
         end
         if (match >= 0) begin
            if (sess_dest[match] < n && !dest_bad[sess_dest[match]]) begin
               p.target = sess_dest[match];
               p.from_session = 1'b1;
               have = 1'b1;
               sess_time[match] = w.now;
            end else begin
               sess_valid[match] = 1'b0;   // stuck on a bad destination
            end
         end
         if (!have) begin
            for (int i = 0; i < MaxSessions; i++) begin
               if (!sess_valid[i]) begin
                  sess_valid[i] = 1'b1;
                  sess_addr[i] = w.client_addr;
                  sess_time[i] = w.now;
                  slot = i;
                  break;
               end
            end
            if (slot < 0) p.table_full = 1'b1;
         end
      end
      if (!have) begin
         if (cfg_only_first) rr_started = 1'b0;
         for (int t = 0; t < n; t++) begin
            c = 0;
            if (rr_started) begin
               c = rr_last + 1;
               if (c >= n) c = 0;
            end
            rr_last = c;
            rr_started = 1'b1;
            if (!dest_bad[c]) begin
               p.target = c;
               have = 1'b1;
               break;
            end
            if (cfg_retry_time != 0 &&
                {32'd0, w.now} > {32'd0, dest_fail_time[c]} + {32'd0, cfg_retry_time}) begin
               dest_bad[c] = 1'b0;
               p.target = c;
               p.revived = 1'b1;
               have = 1'b1;
               break;
            end
         end
      end
      if (!have) begin
         // everything down: clear all health and restart at zero
         for (int i = 0; i < MaxTargets; i++) dest_bad[i] = 1'b0;
         p.target = '0;
         rr_last = '0;
         rr_started = 1'b1;
         p.fallback = 1'b1;
      end
      if (slot >= 0) sess_dest[slot] = p.target;
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued words, holds each until accepted.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) expected_picks.push_back(predict_pick(
               '{req_opcode, req_client_addr, req_now, req_fail_target}));
         if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
            conn_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_opcode <= w.opcode;
            req_client_addr <= w.client_addr;
            req_now <= w.now;
            req_fail_target <= w.fail_target;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, compare each response to oldest expect.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 7);
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               $display("%0t: unexpected response target=%0d", $time, rsp_target);
               error_count++;
            end else begin
               pick_word_type e;
               e = expected_picks.pop_front();
               if ({rsp_target, rsp_from_session, rsp_revived, rsp_fallback,
                    rsp_table_full} !== {e.target, e.from_session, e.revived,
                    e.fallback, e.table_full}) begin
                  $display("%0t: mismatch expected tgt=%0d ses=%b rev=%b fb=%b full=%b",
                           $time, e.target, e.from_session, e.revived, e.fallback,
                           e.table_full);
                  $display("%0t:          actual   tgt=%0d ses=%b rev=%b fb=%b full=%b",
                           $time, rsp_target, rsp_from_session, rsp_revived,
                           rsp_fallback, rsp_table_full);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no traffic on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // APB write: setup cycle, access cycle; predictor shadow updated with it.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         RegNumTargets:  cfg_num_targets = value[4:0];
         RegOnlyFirst:   cfg_only_first = value[0];
         RegSessionMode: cfg_session_mode = value[0];
         RegRetryTime:   cfg_retry_time = value;
         RegSessTimeout: cfg_sess_timeout = value;
         default: ;
      endcase
   endtask

   // Wait until all words are in, every response back, block settled.
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_picks.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic push_word(input logic op, input logic [31:0] addr,
                            input logic [31:0] t, input logic [3:0] ft);
      pending_words.push_back('{op, addr, t, ft});
   endtask

   // Random phase: mostly selects from a small client pool with steady time,
   // failure reports sprinkled in, occasional odd time jumps.
   task automatic random_phase(input int count, input int pool);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 3) clock_now = $urandom;
         else clock_now = clock_now + $urandom_range(40);
         if (r < 20)
            push_word(OpFail, $urandom, clock_now, $urandom_range(15));
         else if ($urandom_range(9) == 0)
            push_word(OpSelect, $urandom, clock_now, $urandom_range(15));
         else
            push_word(OpSelect, 32'h0a00_0000 + $urandom_range(pool - 1),
                      clock_now, $urandom_range(15));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, single destination, failure and fallback.
      push_word(OpSelect, 32'h0000_0000, 32'h0, 4'h0);
      push_word(OpSelect, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      push_word(OpFail, 32'h0, 32'd10, 4'h0);
      push_word(OpSelect, 32'h1, 32'd11, 4'h0);      // all bad -> fallback
      push_word(OpFail, 32'h0, 32'd12, 4'hf);        // index beyond count
      drain();

      csr_write(RegNumTargets, 32'd4);
      csr_write(RegRetryTime, 32'd5);
      push_word(OpSelect, 32'h2, 32'd20, 4'h0);
      push_word(OpSelect, 32'h2, 32'd21, 4'h0);
      push_word(OpFail, 32'h0, 32'd22, 4'd2);
      push_word(OpFail, 32'h0, 32'd22, 4'd3);
      push_word(OpSelect, 32'h3, 32'd23, 4'h0);      // skips bad ones
      push_word(OpSelect, 32'h3, 32'd28, 4'h0);      // next good one, no revive
      push_word(OpFail, 32'h0, 32'hffff_fff0, 4'd1);
      push_word(OpSelect, 32'h3, 32'hffff_ffff, 4'h0); // revives a bad destination
      drain();

      // Session mode, tiny timeout, session on a bad destination.
      csr_write(RegSessionMode, 32'd1);
      csr_write(RegSessTimeout, 32'd10);
      csr_write(RegOnlyFirst, 32'd1);
      push_word(OpSelect, 32'haaaa_0001, 32'd100, 4'h0);
      push_word(OpSelect, 32'haaaa_0001, 32'd105, 4'h0);
      push_word(OpFail, 32'h0, 32'd106, 4'd0);
      push_word(OpSelect, 32'haaaa_0001, 32'd107, 4'h0);
      push_word(OpSelect, 32'haaaa_0001, 32'd200, 4'h0); // expired
      push_word(OpSelect, 32'haaaa_0002, 32'd5, 4'h0);   // time going back
      drain();

      // Extremes of the registers, then a count above the limit.
      csr_write(RegNumTargets, 32'd0);
      csr_write(RegOnlyFirst, 32'd0);
      csr_write(RegRetryTime, 32'hffff_ffff);
      csr_write(RegSessTimeout, 32'd0);
      push_word(OpSelect, 32'h5, 32'd300, 4'h0);
      push_word(OpSelect, 32'h5, 32'd300, 4'h0);
      drain();
      csr_write(RegNumTargets, 32'd31);
      csr_write(RegSessTimeout, 32'hffff_ffff);
      csr_write(RegRetryTime, 32'd30);

      // Fill the session table past its size.
      for (int i = 0; i < MaxSessions + 4; i++)
         push_word(OpSelect, 32'hc000_0000 + i, clock_now, 4'h0);
      drain();

      // Long stretch with no idling, then random phases across settings.
      calm = 1'b1;
      csr_write(RegNumTargets, 32'd16);
      csr_write(RegSessTimeout, 32'd200);
      random_phase(150, 40);
      drain();
      calm = 1'b0;

      csr_write(RegSessionMode, 32'd0);
      csr_write(RegNumTargets, 32'd5);
      csr_write(RegRetryTime, 32'd0);
      random_phase(150, 20);
      drain();

      csr_write(RegSessionMode, 32'd1);
      csr_write(RegOnlyFirst, 32'd1);
      csr_write(RegNumTargets, 32'd3);
      csr_write(RegRetryTime, 32'd50);
      csr_write(RegSessTimeout, 32'd400);
      random_phase(150, 90);
      drain();

      csr_write(RegOnlyFirst, 32'd0);
      csr_write(RegNumTargets, 32'd9);
      csr_write(RegRetryTime, 32'd15);
      random_phase(150, 12);
      drain();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// File: filelist.f
rtl/frrs_pkg.sv
rtl/frrs_cell.sv
rtl/failover_round_robin_selector_core.sv
verif/failover_round_robin_selector_core_tb.sv
